/* src/dtc_pkg.sv */
// ----------------------------------------------------------------------------
// dtc_pkg : shared types and constants
// Configuration record, per-channel filter state, result record and the
// soft-limit table, built at elaboration.
// ----------------------------------------------------------------------------
package dtc_pkg;

	localparam int CHANNELS     = 2;
	localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int TANH_ENTRIES = 512;                 // power of two
	localparam int TANH_BITS    = $clog2(TANH_ENTRIES);
	localparam int FRAC_BITS    = 25 - TANH_BITS;
	localparam int TAB_AW       = $clog2(TANH_ENTRIES + 1);
	localparam int SAMPLE_W     = 24;
	localparam int CFG_W        = 24;
	localparam int CFG_IDX_W    = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HP_COEFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_B0    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_B1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_B2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_A1    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TONE_A2    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL  = 3'd7;

	typedef struct packed {
		logic        [15:0] drive_gain;
		logic        [22:0] hp_coeff;
		logic signed [23:0] tone_b0;
		logic signed [23:0] tone_b1;
		logic signed [23:0] tone_b2;
		logic signed [23:0] tone_a1;
		logic signed [23:0] tone_a2;
		logic        [15:0] out_level;
	} cfg_t;

	// one memory word: all filter state of one channel
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] z1;
		logic signed [31:0] z2;
		logic signed [31:0] ox;
		logic signed [31:0] oy;
	} chan_state_t;

	typedef struct packed {
		logic                       done;
		logic                       chan;
		logic signed [SAMPLE_W-1:0] sample;
	} result_t;

	typedef logic [23:0] tanh_tab_t [TANH_ENTRIES+1];

	localparam logic [63:0] ONE_Q62 = 64'd1 << 62;

	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	function automatic tanh_tab_t build_tanh();
		tanh_tab_t   tab;
		logic [63:0] d, step, term, e, num, den, r, q;
		d    = (ONE_Q62 / TANH_ENTRIES) * 64'd8 + ((ONE_Q62 % TANH_ENTRIES) * 64'd8) / TANH_ENTRIES;
		step = ONE_Q62;
		term = ONE_Q62;
		e    = ONE_Q62;
		for (int i = 1; i <= 24; i++) begin
			term = mul_q62(term, d) / 64'(i);
			if (i % 2 == 1) step = step - term;
			else step = step + term;
		end
		for (int k = 0; k <= TANH_ENTRIES; k++) begin
			num = ONE_Q62 - e;
			den = ONE_Q62 + e;
			r   = num;
			q   = 64'd0;
			for (int b = 0; b < 24; b++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r = r - den;
					q = q | 64'd1;
				end
			end
			tab[k] = 24'((q + 64'd1) >> 1);
			e = mul_q62(e, step);
		end
		return tab;
	endfunction

	localparam tanh_tab_t TANH_TAB = build_tanh();

endpackage

/* src/dtc_ifs.sv */
// ----------------------------------------------------------------------------
// dtc_in_if / dtc_out_if : sample channels
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dtc_in_if;
	logic                 valid;
	logic                 ready;
	logic                 chan;
	logic signed [23:0]   sample_in;
	modport source (output valid, chan, sample_in, input ready);
	modport sink   (input valid, chan, sample_in, output ready);
endinterface

interface dtc_out_if;
	logic                 valid;
	logic                 ready;
	logic                 chan_out;
	logic signed [23:0]   sample_out;
	modport source (output valid, chan_out, sample_out, input ready);
	modport sink   (input valid, chan_out, sample_out, output ready);
endinterface

/* src/distortion_tone_chain.sv */
// ----------------------------------------------------------------------------
// distortion_tone_chain : per-channel distortion and tone chain
// DC blocker, drive, asymmetric clip, shelf biquad, level, DC blocker and
// tanh soft limit on Q1.23 samples, state kept per channel.
// ----------------------------------------------------------------------------
// Use:
//  in_ch  : one item = chan + sample_in; taken when valid and ready are high.
//  out_ch : one item = chan_out + sample_out per input item, in order.
//  cfg_*  : plain write port, register index cfg_idx, data cfg_wdata;
//           write only while no item is in flight.
// Timing: one item at a time. An item passes from acceptance to the output
//  register through a chain of eleven products on a single shared
//  multiplier, each a multiply step then a use step, plus the table read
//  and the handover step.
//  in_ch.ready is high whenever the sequencer is idle, so a new item is taken
//  while a finished one still waits on out_ch; a new item is not taken
//  before the previous one has been handed over.
// Stall: if out_ch is held off, the finished item waits in the sequencer's
//  last step and state write-back waits with it.
// Reset: arst_n clears the sequencer, the output valid and the per-channel
//  valid bits; state of every channel then reads as zero. Configuration
//  registers return to their defaults.
// ----------------------------------------------------------------------------
module distortion_tone_chain (
	input  logic                              clk,
	input  logic                              arst_n,
	dtc_in_if.sink                            in_ch,
	dtc_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [dtc_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [dtc_pkg::CFG_W-1:0]         cfg_wdata
);
	import dtc_pkg::*;

	cfg_t    cfg_q;
	result_t res;
	logic    idle;
	logic    start;
	logic    out_free;
	logic    out_valid_q;
	logic    chan_out_q;
	logic signed [SAMPLE_W-1:0] sample_out_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.drive_gain <= 16'd1280;
			cfg_q.hp_coeff   <= 23'd8355840;
			cfg_q.tone_b0    <= 24'sd524288;
			cfg_q.tone_b1    <= '0;
			cfg_q.tone_b2    <= '0;
			cfg_q.tone_a1    <= '0;
			cfg_q.tone_a2    <= '0;
			cfg_q.out_level  <= 16'd20480;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_DRIVE_GAIN: cfg_q.drive_gain <= cfg_wdata[15:0];
				REG_HP_COEFF:   cfg_q.hp_coeff   <= cfg_wdata[22:0];
				REG_TONE_B0:    cfg_q.tone_b0    <= cfg_wdata;
				REG_TONE_B1:    cfg_q.tone_b1    <= cfg_wdata;
				REG_TONE_B2:    cfg_q.tone_b2    <= cfg_wdata;
				REG_TONE_A1:    cfg_q.tone_a1    <= cfg_wdata;
				REG_TONE_A2:    cfg_q.tone_a2    <= cfg_wdata;
				REG_OUT_LEVEL:  cfg_q.out_level  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_ch.ready = idle;
	assign start       = in_ch.valid && idle;
	// the slot is free if empty or being emptied this cycle
	assign out_free    = !out_valid_q || out_ch.ready;

	dtc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.start(start), .chan(in_ch.chan), .sample_in(in_ch.sample_in),
		.out_free(out_free), .idle(idle), .res(res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			chan_out_q   <= res.chan;
			sample_out_q <= res.sample;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.chan_out   = chan_out_q;
	assign out_ch.sample_out = sample_out_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |-> !res.done) else $error("result overwritten");
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ch.ready) else $error("second item taken while busy");
	a_done_fills: assert property (@(posedge clk) disable iff (!arst_n)
		res.done |=> out_valid_q) else $error("result lost");

endmodule

/* src/dtc_state_mem.sv */
// ----------------------------------------------------------------------------
// dtc_state_mem : per-channel filter state memory
// One word per channel, registered read; unwritten words read as zero.
// ----------------------------------------------------------------------------
module dtc_state_mem (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [dtc_pkg::CH_W-1:0]    rd_addr,
	output dtc_pkg::chan_state_t        rd_data,
	input  logic                        wr_en,
	input  logic [dtc_pkg::CH_W-1:0]    wr_addr,
	input  dtc_pkg::chan_state_t        wr_data
);
	import dtc_pkg::*;

	chan_state_t         mem [CHANNELS];
	logic [CHANNELS-1:0] valid_q;
	chan_state_t         rd_q;
	logic                rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (rd_en) rd_valid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

/* src/dtc_tanh_rom.sv */
// ----------------------------------------------------------------------------
// dtc_tanh_rom : soft-limit table
// Two registered read ports onto the tanh table, for interpolation.
// ----------------------------------------------------------------------------
module dtc_tanh_rom (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [dtc_pkg::TAB_AW-1:0] addr_lo,
	input  logic [dtc_pkg::TAB_AW-1:0] addr_hi,
	output logic [23:0]                data_lo,
	output logic [23:0]                data_hi
);
	import dtc_pkg::*;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_lo <= TANH_TAB[addr_lo];
			data_hi <= TANH_TAB[addr_hi];
		end
	end

endmodule

/* src/dtc_datapath.sv */
// ----------------------------------------------------------------------------
// dtc_datapath : sequenced chain with one shared multiplier
// Reads the channel's state word, runs the chain as a multiply step and a
// use step per product, writes the state back when the result is handed over.
// ----------------------------------------------------------------------------
module dtc_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dtc_pkg::cfg_t                 cfg,
	input  logic                          start,
	input  logic                          chan,
	input  logic signed [23:0]            sample_in,
	input  logic                          out_free,
	output logic                          idle,
	output dtc_pkg::result_t              res
);
	import dtc_pkg::*;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_HP1_M = 5'd1;
	localparam logic [4:0] ST_HP1_C = 5'd2;
	localparam logic [4:0] ST_DRV_M = 5'd3;
	localparam logic [4:0] ST_DRV_C = 5'd4;
	localparam logic [4:0] ST_B0_M  = 5'd5;
	localparam logic [4:0] ST_B0_C  = 5'd6;
	localparam logic [4:0] ST_B1_M  = 5'd7;
	localparam logic [4:0] ST_B1_C  = 5'd8;
	localparam logic [4:0] ST_A1_M  = 5'd9;
	localparam logic [4:0] ST_A1_C  = 5'd10;
	localparam logic [4:0] ST_B2_M  = 5'd11;
	localparam logic [4:0] ST_B2_C  = 5'd12;
	localparam logic [4:0] ST_A2_M  = 5'd13;
	localparam logic [4:0] ST_A2_C  = 5'd14;
	localparam logic [4:0] ST_LVL_M = 5'd15;
	localparam logic [4:0] ST_LVL_C = 5'd16;
	localparam logic [4:0] ST_HP2_M = 5'd17;
	localparam logic [4:0] ST_HP2_C = 5'd18;
	localparam logic [4:0] ST_SL_M  = 5'd19;
	localparam logic [4:0] ST_SL_C  = 5'd20;
	localparam logic [4:0] ST_ROM   = 5'd21;
	localparam logic [4:0] ST_LUT_M = 5'd22;
	localparam logic [4:0] ST_LUT_C = 5'd23;
	localparam logic [4:0] ST_DONE  = 5'd24;

	localparam logic signed [65:0] CLIP_HI = 66'sd5872026;
	localparam logic signed [65:0] CLIP_LO = -66'sd4194304;
	localparam logic signed [32:0] SL_GAIN = 33'sd45875;   // 0.7 in Q0.16

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [4:0]                step_q;
	logic [CH_W-1:0]           ch_q;
	logic                      chan_q;
	logic signed [31:0]        x_q, y1_q, y_q, z1n_q, z2n_q, v_q, w_q;
	logic signed [23:0]        g_q;
	logic signed [65:0]        acc_q, prod_q;
	logic signed [32:0]        mul_a, mul_b;
	logic                      neg_q, sat_q;
	logic [TAB_AW-1:0]         idx_q;
	logic [24:0]               f_q;
	logic signed [SAMPLE_W-1:0] out_q;
	chan_state_t               st, wb;
	logic [TAB_AW-1:0]         addr_lo, addr_hi;
	logic [23:0]               tab_lo, tab_hi;
	logic signed [24:0]        tab_diff;
	logic [CH_W-1:0]           ch_sel;
	logic                      wr_en;
	logic signed [65:0]        hp1_sum, hp2_sum, g_full, s_full;
	logic signed [32:0]        s33, a33;
	logic [23:0]               t_sum;

	assign ch_sel = (32'(chan) >= CHANNELS) ? '0 : CH_W'(chan);
	assign wr_en  = (step_q == ST_DONE) && out_free;
	assign wb     = '{px: x_q, py: y1_q, z1: z1n_q, z2: z2n_q, ox: v_q, oy: w_q};

	dtc_state_mem u_mem (
		.clk(clk), .arst_n(arst_n),
		.rd_en(start), .rd_addr(ch_sel), .rd_data(st),
		.wr_en(wr_en), .wr_addr(ch_q), .wr_data(wb)
	);

	assign addr_lo = sat_q ? TAB_AW'(TANH_ENTRIES) : idx_q;
	assign addr_hi = sat_q ? TAB_AW'(TANH_ENTRIES) : idx_q + 1'b1;

	dtc_tanh_rom u_rom (
		.clk(clk), .rd_en(step_q == ST_ROM),
		.addr_lo(addr_lo), .addr_hi(addr_hi),
		.data_lo(tab_lo), .data_hi(tab_hi)
	);

	assign tab_diff = $signed({1'b0, tab_hi}) - $signed({1'b0, tab_lo});

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (step_q)
			ST_HP1_M: begin mul_a = {10'd0, cfg.hp_coeff}; mul_b = 33'(st.py); end
			ST_DRV_M: begin mul_a = 33'(y1_q); mul_b = {17'd0, cfg.drive_gain}; end
			ST_B0_M:  begin mul_a = 33'(cfg.tone_b0); mul_b = 33'(g_q); end
			ST_B1_M:  begin mul_a = 33'(cfg.tone_b1); mul_b = 33'(g_q); end
			ST_A1_M:  begin mul_a = 33'(cfg.tone_a1); mul_b = 33'(y_q); end
			ST_B2_M:  begin mul_a = 33'(cfg.tone_b2); mul_b = 33'(g_q); end
			ST_A2_M:  begin mul_a = 33'(cfg.tone_a2); mul_b = 33'(y_q); end
			ST_LVL_M: begin mul_a = 33'(y_q); mul_b = {17'd0, cfg.out_level}; end
			ST_HP2_M: begin mul_a = {10'd0, cfg.hp_coeff}; mul_b = 33'(st.oy); end
			ST_SL_M:  begin mul_a = 33'(w_q); mul_b = SL_GAIN; end
			ST_LUT_M: begin mul_a = 33'(tab_diff); mul_b = sat_q ? '0 : {8'd0, f_q}; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign hp1_sum = 66'(x_q) - 66'(st.px) + (prod_q >>> 23);
	assign hp2_sum = 66'(v_q) - 66'(st.ox) + (prod_q >>> 23);
	assign g_full  = prod_q >>> 8;
	assign s_full  = prod_q >>> 16;
	assign s33     = s_full[32:0];
	assign a33     = s33[32] ? -s33 : s33;
	assign t_sum   = tab_lo + prod_q[48:25];

	// payload registers
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= 32'(sample_in);
			ch_q   <= ch_sel;
			chan_q <= chan;
		end
		case (step_q)
			ST_HP1_C: y1_q <= sat32(hp1_sum);
			ST_DRV_C: begin
				if (g_full > CLIP_HI) g_q <= CLIP_HI[23:0];
				else if (g_full < CLIP_LO) g_q <= CLIP_LO[23:0];
				else g_q <= g_full[23:0];
			end
			ST_B0_C:  y_q   <= sat32((prod_q >>> 19) + 66'(st.z1));
			ST_B1_C:  acc_q <= prod_q;
			ST_A1_C:  z1n_q <= sat32(((acc_q - prod_q) >>> 19) + 66'(st.z2));
			ST_B2_C:  acc_q <= prod_q;
			ST_A2_C:  z2n_q <= sat32((acc_q - prod_q) >>> 19);
			ST_LVL_C: v_q   <= sat32(prod_q >>> 14);
			ST_HP2_C: w_q   <= sat32(hp2_sum);
			ST_SL_C: begin
				neg_q <= s33[32];
				sat_q <= |a33[31:25];
				idx_q <= TAB_AW'(a33[24:FRAC_BITS]);
				f_q   <= {a33[FRAC_BITS-1:0], {TANH_BITS{1'b0}}};
			end
			ST_LUT_C: out_q <= neg_q ? -$signed(t_sum) : $signed(t_sum);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			case (step_q)
				ST_IDLE: if (start) step_q <= ST_HP1_M;
				ST_DONE: if (out_free) step_q <= ST_IDLE;
				default: step_q <= step_q + 5'd1;
			endcase
		end
	end

	assign idle       = (step_q == ST_IDLE);
	assign res.done   = wr_en;
	assign res.chan   = chan_q;
	assign res.sample = out_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> step_q == ST_IDLE) else $error("start while busy");
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> step_q == ST_HP1_M) else $error("sequence did not begin");
	a_wb_done: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> step_q == ST_IDLE) else $error("write-back outside handover");
	a_sat_top: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_ROM && sat_q) |-> addr_lo == TAB_AW'(TANH_ENTRIES))
		else $error("saturated lookup off top entry");

endmodule
